>>> rtl/slp_pkg.sv
// shared types, codes and the crc-8 step for the slip led packet receiver
package slp_pkg;

  // slip framing bytes
  localparam logic [7:0] SLIP_END  = 8'hC0;
  localparam logic [7:0] SLIP_ESC  = 8'hDB;
  localparam logic [7:0] SLIP_TEND = 8'hDC;
  localparam logic [7:0] SLIP_TESC = 8'hDD;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_MY_ADDRESS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BCAST_ADDRESS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CRC_POLYNOMIAL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_NOOP      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_RGB       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_LATCH     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_RGB_LATCH = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_BAUD      = 3'd7;

  // frame status codes
  localparam logic [2:0] ST_COMPLETE   = 3'd0;
  localparam logic [2:0] ST_INCOMPLETE = 3'd1;
  localparam logic [2:0] ST_OVERRUN    = 3'd2;
  localparam logic [2:0] ST_BAD_CRC    = 3'd3;
  localparam logic [2:0] ST_BAD_TYPE   = 3'd4;

  typedef struct packed {
    logic [7:0] my_address;
    logic [7:0] broadcast_address;
    logic [7:0] crc_polynomial;
    logic [7:0] code_noop;
    logic [7:0] code_rgb;
    logic [7:0] code_latch;
    logic [7:0] code_rgb_latch;
    logic [7:0] code_baud;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  frame_status;
    logic        do_noop;
    logic        do_rgb;
    logic        do_latch;
    logic        do_baud;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [23:0] baud_rate;
  } result_t;

  // one byte through the msb-first crc-8, eight shift steps
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b,
                                           input logic [7:0] poly);
    logic [7:0] v;
    v = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (v[7]) begin
        v = {v[6:0], 1'b0} ^ poly;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

>>> rtl/slp_if.sv
// word channels: raw bus bytes in, frame reports out
interface slp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface slp_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  frame_status;
  logic        do_noop;
  logic        do_rgb;
  logic        do_latch;
  logic        do_baud;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [23:0] baud_rate;

  modport source (output valid, output frame_status, output do_noop, output do_rgb,
                  output do_latch, output do_baud, output red, output green,
                  output blue, output baud_rate, input ready);
  modport sink   (input valid, input frame_status, input do_noop, input do_rgb,
                  input do_latch, input do_baud, input red, input green,
                  input blue, input baud_rate, output ready);
endinterface

>>> rtl/slp_cfg_regs.sv
// configuration register bank
module slp_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [slp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_wdata,
  output slp_pkg::cfg_t                 cfg
);

  slp_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.my_address        <= 8'd0;
      cfg_r.broadcast_address <= 8'd255;
      cfg_r.crc_polynomial    <= 8'd7;
      cfg_r.code_noop         <= 8'd0;
      cfg_r.code_rgb          <= 8'd1;
      cfg_r.code_latch        <= 8'd2;
      cfg_r.code_rgb_latch    <= 8'd3;
      cfg_r.code_baud         <= 8'd4;
    end else if (cfg_we) begin
      unique case (cfg_index)
        slp_pkg::CFG_MY_ADDRESS:     cfg_r.my_address        <= cfg_wdata;
        slp_pkg::CFG_BCAST_ADDRESS:  cfg_r.broadcast_address <= cfg_wdata;
        slp_pkg::CFG_CRC_POLYNOMIAL: cfg_r.crc_polynomial    <= cfg_wdata;
        slp_pkg::CFG_CODE_NOOP:      cfg_r.code_noop         <= cfg_wdata;
        slp_pkg::CFG_CODE_RGB:       cfg_r.code_rgb          <= cfg_wdata;
        slp_pkg::CFG_CODE_LATCH:     cfg_r.code_latch        <= cfg_wdata;
        slp_pkg::CFG_CODE_RGB_LATCH: cfg_r.code_rgb_latch    <= cfg_wdata;
        slp_pkg::CFG_CODE_BAUD:      cfg_r.code_baud         <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/slp_parser.sv
// slip unescape and packet parser state, one raw byte per step
module slp_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  slp_pkg::cfg_t    cfg,
  input  logic             step,
  input  logic [7:0]       raw_byte,
  output logic             res_fire,
  output slp_pkg::result_t res
);

  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_TYPE    = 4'd1;
  localparam logic [3:0] PH_BAUD1   = 4'd2;
  localparam logic [3:0] PH_BAUD2   = 4'd3;
  localparam logic [3:0] PH_BAUD3   = 4'd4;
  localparam logic [3:0] PH_COUNT   = 4'd5;
  localparam logic [3:0] PH_RED     = 4'd6;
  localparam logic [3:0] PH_GREEN   = 4'd7;
  localparam logic [3:0] PH_BLUE    = 4'd8;
  localparam logic [3:0] PH_CRC     = 4'd9;
  localparam logic [3:0] PH_END     = 4'd10;
  localparam logic [3:0] PH_OVERRUN = 4'd11;
  localparam logic [3:0] PH_BADCRC  = 4'd12;
  localparam logic [3:0] PH_BADTYPE = 4'd13;

  localparam logic [2:0] KIND_NONE  = 3'd0;
  localparam logic [2:0] KIND_NOOP  = 3'd1;
  localparam logic [2:0] KIND_RGB   = 3'd2;
  localparam logic [2:0] KIND_LATCH = 3'd3;
  localparam logic [2:0] KIND_RGBL  = 3'd4;
  localparam logic [2:0] KIND_BAUD  = 3'd5;

  typedef struct packed {
    logic [3:0]  phase;
    logic        esc;
    logic [7:0]  crc;
    logic [7:0]  dest;
    logic [7:0]  taddr;
    logic        found;
    logic [7:0]  kind;
    logic [23:0] baud;
    logic [7:0]  left;
    logic [7:0]  pend_r;
    logic [7:0]  pend_g;
    logic [7:0]  held_r;
    logic [7:0]  held_g;
    logic [7:0]  held_b;
  } pstate_t;

  pstate_t st_r, st_nxt;

  // first match wins on equal codes
  function automatic logic [2:0] classify(input logic [7:0] t, input slp_pkg::cfg_t c);
    if (t == c.code_noop)      return KIND_NOOP;
    if (t == c.code_rgb)       return KIND_RGB;
    if (t == c.code_latch)     return KIND_LATCH;
    if (t == c.code_rgb_latch) return KIND_RGBL;
    if (t == c.code_baud)      return KIND_BAUD;
    return KIND_NONE;
  endfunction

  logic       parse_en;
  logic [7:0] d;
  logic [7:0] crc_upd;
  logic [7:0] left_dec;
  logic [2:0] kind_in;
  logic [2:0] kind_end;
  logic [7:0] eff;

  // unescape front end
  always_comb begin
    parse_en = 1'b0;
    d        = raw_byte;
    res_fire = 1'b0;
    if (st_r.esc) begin
      if (raw_byte == slp_pkg::SLIP_TEND) begin
        parse_en = 1'b1;
        d        = slp_pkg::SLIP_END;
      end else if (raw_byte == slp_pkg::SLIP_TESC) begin
        parse_en = 1'b1;
        d        = slp_pkg::SLIP_ESC;
      end
    end else if (raw_byte == slp_pkg::SLIP_END) begin
      res_fire = 1'b1;
    end else if (raw_byte != slp_pkg::SLIP_ESC) begin
      parse_en = 1'b1;
    end
  end

  assign crc_upd  = slp_pkg::crc8_byte((st_r.phase == PH_IDLE) ? 8'd0 : st_r.crc, d,
                                       cfg.crc_polynomial);
  assign left_dec = st_r.left - 8'd1;
  assign kind_in  = classify(d, cfg);

  // next state
  always_comb begin
    st_nxt     = st_r;
    st_nxt.esc = !st_r.esc && (raw_byte == slp_pkg::SLIP_ESC);
    if (res_fire) begin
      st_nxt.phase = PH_IDLE;
    end else if (parse_en) begin
      unique case (st_r.phase)
        PH_IDLE: begin
          st_nxt.crc   = crc_upd;
          st_nxt.dest  = d;
          st_nxt.taddr = d;
          st_nxt.found = 1'b0;
          st_nxt.phase = PH_TYPE;
        end
        PH_TYPE: begin
          st_nxt.crc  = crc_upd;
          st_nxt.kind = d;
          case (kind_in)
            KIND_NOOP, KIND_LATCH: st_nxt.phase = PH_CRC;
            KIND_RGB, KIND_RGBL:   st_nxt.phase = PH_COUNT;
            KIND_BAUD:             st_nxt.phase = PH_BAUD1;
            default:               st_nxt.phase = PH_BADTYPE;
          endcase
        end
        PH_BAUD1: begin
          st_nxt.crc   = crc_upd;
          st_nxt.baud  = {16'd0, d};
          st_nxt.phase = PH_BAUD2;
        end
        PH_BAUD2: begin
          st_nxt.crc   = crc_upd;
          st_nxt.baud  = {st_r.baud[15:0], d};
          st_nxt.phase = PH_BAUD3;
        end
        PH_BAUD3: begin
          st_nxt.crc   = crc_upd;
          st_nxt.baud  = {st_r.baud[15:0], d};
          st_nxt.phase = PH_CRC;
        end
        PH_COUNT: begin
          st_nxt.crc   = crc_upd;
          st_nxt.left  = d;
          st_nxt.phase = PH_RED;
        end
        PH_RED: begin
          st_nxt.crc    = crc_upd;
          st_nxt.pend_r = d;
          st_nxt.phase  = PH_GREEN;
        end
        PH_GREEN: begin
          st_nxt.crc    = crc_upd;
          st_nxt.pend_g = d;
          st_nxt.phase  = PH_BLUE;
        end
        PH_BLUE: begin
          st_nxt.crc = crc_upd;
          if (st_r.taddr == cfg.my_address || st_r.taddr == cfg.broadcast_address) begin
            st_nxt.held_r = st_r.pend_r;
            st_nxt.held_g = st_r.pend_g;
            st_nxt.held_b = d;
            st_nxt.found  = 1'b1;
          end
          st_nxt.taddr = st_r.taddr + 8'd1;
          st_nxt.left  = left_dec;
          st_nxt.phase = (left_dec != 8'd0) ? PH_RED : PH_CRC;
        end
        PH_CRC:  st_nxt.phase = (d == st_r.crc) ? PH_END : PH_BADCRC;
        PH_END:  st_nxt.phase = PH_OVERRUN;
        default: ;
      endcase
    end
  end

  // frame report from the state before the end byte
  assign eff      = st_r.found ? cfg.my_address : st_r.dest;
  assign kind_end = classify(st_r.kind, cfg);

  always_comb begin
    res.do_noop  = 1'b0;
    res.do_rgb   = 1'b0;
    res.do_latch = 1'b0;
    res.do_baud  = 1'b0;
    case (st_r.phase)
      PH_END:     res.frame_status = slp_pkg::ST_COMPLETE;
      PH_OVERRUN: res.frame_status = slp_pkg::ST_OVERRUN;
      PH_BADCRC:  res.frame_status = slp_pkg::ST_BAD_CRC;
      PH_BADTYPE: res.frame_status = slp_pkg::ST_BAD_TYPE;
      default:    res.frame_status = slp_pkg::ST_INCOMPLETE;
    endcase
    if (st_r.phase == PH_END &&
        (eff == cfg.my_address || eff == cfg.broadcast_address)) begin
      case (kind_end)
        KIND_NOOP:  res.do_noop = 1'b1;
        KIND_RGB:   res.do_rgb  = (st_r.left == 8'd0);
        KIND_LATCH: res.do_latch = 1'b1;
        KIND_RGBL: begin
          res.do_rgb   = (st_r.left == 8'd0);
          res.do_latch = 1'b1;
        end
        KIND_BAUD:  res.do_baud = (eff == cfg.broadcast_address);
        default: ;
      endcase
    end
    res.red       = st_r.held_r;
    res.green     = st_r.held_g;
    res.blue      = st_r.held_b;
    res.baud_rate = st_r.baud;
  end

  // idle phase is code zero, so clearing the whole state idles the parser
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (step) begin
      st_r <= st_nxt;
    end
  end

endmodule

>>> rtl/slip_led_packet_receiver.sv
// top level: slip led packet receiver with input word register and result register
//
//   channel   dir   handshake           payload
//   in_if     in    valid/ready         rx_byte[7:0]
//   out_if    out   valid/ready         frame_status, do_*, red/green/blue, baud_rate
//   cfg_*     in    cfg_we (no wait)    cfg_index[2:0], cfg_wdata[7:0]
//
// one word per cycle unless an end word waits on a stalled report; a word's
// parser step (byte-wide crc unrolled into the step) runs from the input register
// a report passes from the parser through the result register to out_if
// reset (rst_n low, synchronous) restores register defaults and idles the parser
// a stalled report holds the output register; only end words wait on it
module slip_led_packet_receiver (
  input  logic                          clk,
  input  logic                          rst_n,
  slp_byte_if.sink                      in_if,
  slp_result_if.source                  out_if,
  input  logic                          cfg_we,
  input  logic [slp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_wdata
);

  slp_pkg::cfg_t    cfg;
  slp_pkg::result_t res;
  slp_pkg::result_t out_data_r;
  logic             res_fire;
  logic             in_vld_r;
  logic [7:0]       in_byte_r;
  logic             out_vld_r;
  logic             advance;

  slp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  slp_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .step     (advance),
    .raw_byte (in_byte_r),
    .res_fire (res_fire),
    .res      (res)
  );

  // the registered word moves on unless it is an end word facing a full, stalled result reg
  assign advance     = in_vld_r && (!res_fire || !out_vld_r || out_if.ready);
  assign in_if.ready = !in_vld_r || advance;

  // input word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_if.ready) begin
      in_vld_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      in_byte_r <= in_if.rx_byte;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance && res_fire) begin
      out_vld_r <= 1'b1;
    end else if (out_if.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_fire) begin
      out_data_r <= res;
    end
  end

  assign out_if.valid        = out_vld_r;
  assign out_if.frame_status = out_data_r.frame_status;
  assign out_if.do_noop      = out_data_r.do_noop;
  assign out_if.do_rgb       = out_data_r.do_rgb;
  assign out_if.do_latch     = out_data_r.do_latch;
  assign out_if.do_baud      = out_data_r.do_baud;
  assign out_if.red          = out_data_r.red;
  assign out_if.green        = out_data_r.green;
  assign out_if.blue         = out_data_r.blue;
  assign out_if.baud_rate    = out_data_r.baud_rate;

endmodule

>>> rtl/slp_checker.sv
// port-level assertions for the slip led packet receiver, bound to the top level
module slp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] frame_status,
  input logic       do_noop,
  input logic       do_rgb,
  input logic       do_latch,
  input logic       do_baud
);

  // a stalled report holds valid, its status and its rgb flag
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(frame_status) && $stable(do_rgb))
    else $error("stalled report changed");

  // no report right after reset
  a_reset: assert property (@(posedge clk) $past(!rst_n) |-> !out_valid)
    else $error("report valid right after reset");

  // actions only on a complete frame
  a_act: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (do_noop || do_rgb || do_latch || do_baud) |->
      frame_status == slp_pkg::ST_COMPLETE)
    else $error("action on a failed frame");

  // noop, baud and the colour actions come from different packet types
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0({do_noop, do_baud, do_rgb || do_latch}))
    else $error("actions of different packet types together");

endmodule

bind slip_led_packet_receiver slp_checker u_slp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .frame_status (out_if.frame_status),
  .do_noop      (out_if.do_noop),
  .do_rgb       (out_if.do_rgb),
  .do_latch     (out_if.do_latch),
  .do_baud      (out_if.do_baud)
);

>>> tb/tb_slip_led_packet_receiver.sv
// testbench for the slip led packet receiver: directed frames, then random framed traffic
module tb_slip_led_packet_receiver;

  // parser phases of the predictor
  typedef enum logic [3:0] {
    WAIT_ADDR, WAIT_TYPE, BAUD_HI, BAUD_MID, BAUD_LO, WAIT_COUNT,
    TRIP_R, TRIP_G, TRIP_B, WAIT_CRC, CRC_DONE, TOO_LONG, CRC_FAIL, TYPE_FAIL
  } parse_e;

  // what a type byte decodes to, first match wins
  typedef enum logic [2:0] {K_NONE, K_NOOP, K_RGB, K_LATCH, K_RGB_LATCH, K_BAUD} kind_e;

  // ways a generated frame gets damaged
  typedef enum logic [1:0] {F_CLEAN, F_BAD_CRC, F_TRUNC, F_OVERRUN} fault_e;

  // receiver back-pressure styles
  typedef enum logic [1:0] {PACE_FREE, PACE_BEAT, PACE_RANDOM, PACE_HOLD} pace_e;

  typedef struct {
    logic [7:0]       word;
    bit               typed;
    slp_pkg::result_t want;
  } stim_row_t;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          cfg_we;
  logic [slp_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [7:0]                    cfg_wdata;

  slp_byte_if   byte_ch ();
  slp_result_if report_ch ();

  slip_led_packet_receiver dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (byte_ch),
    .out_if   (report_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // predictor copy of the registers and the parser state
  slp_pkg::cfg_t regs;
  parse_e        ph;
  bit            esc_seen;
  bit            hit_me;
  logic [7:0]    crc_acc;
  logic [7:0]    frame_addr;
  logic [7:0]    trip_addr;
  logic [7:0]    type_byte;
  logic [7:0]    trips_left;
  logic [7:0]    red_tmp;
  logic [7:0]    green_tmp;
  logic [7:0]    shown_r;
  logic [7:0]    shown_g;
  logic [7:0]    shown_b;
  logic [23:0]   baud_sr;

  // frame reports still owed by the dut, oldest first
  slp_pkg::result_t reports_q[$];
  // wire words of the frame being built
  logic [7:0]       line_q[$];
  stim_row_t        stim_rows[$];

  int unsigned burst_left;
  int unsigned words_in;
  int unsigned reports_done;
  int unsigned report_errors;
  int unsigned settings_run;
  int unsigned status_seen[5];

  // msb-first crc-8 over one word with the current polynomial
  function automatic logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] w);
    logic [7:0] r;
    r = crc ^ w;
    repeat (8) r = r[7] ? ((r << 1) ^ regs.crc_polynomial) : (r << 1);
    return r;
  endfunction

  function automatic kind_e kind_of(logic [7:0] t);
    if (t == regs.code_noop) return K_NOOP;
    if (t == regs.code_rgb) return K_RGB;
    if (t == regs.code_latch) return K_LATCH;
    if (t == regs.code_rgb_latch) return K_RGB_LATCH;
    if (t == regs.code_baud) return K_BAUD;
    return K_NONE;
  endfunction

  // one unescaped data word through the packet parser
  function automatic void parse_payload(logic [7:0] w);
    // address through the last blue byte all feed the crc
    if (ph <= TRIP_B) crc_acc = crc8_step((ph == WAIT_ADDR) ? 8'h00 : crc_acc, w);
    case (ph)
      WAIT_ADDR: begin
        frame_addr = w;
        trip_addr  = w;
        hit_me     = 1'b0;
        ph         = WAIT_TYPE;
      end
      WAIT_TYPE: begin
        type_byte = w;
        case (kind_of(w))
          K_NOOP, K_LATCH:    ph = WAIT_CRC;
          K_RGB, K_RGB_LATCH: ph = WAIT_COUNT;
          K_BAUD:             ph = BAUD_HI;
          default:            ph = TYPE_FAIL;
        endcase
      end
      BAUD_HI: begin
        baud_sr = {16'h0000, w};
        ph      = BAUD_MID;
      end
      BAUD_MID: begin
        baud_sr = {baud_sr[15:0], w};
        ph      = BAUD_LO;
      end
      BAUD_LO: begin
        baud_sr = {baud_sr[15:0], w};
        ph      = WAIT_CRC;
      end
      WAIT_COUNT: begin
        // zero wraps to 256 triples through the 8-bit down count
        trips_left = w;
        ph         = TRIP_R;
      end
      TRIP_R: begin
        red_tmp = w;
        ph      = TRIP_G;
      end
      TRIP_G: begin
        green_tmp = w;
        ph        = TRIP_B;
      end
      TRIP_B: begin
        if (trip_addr == regs.my_address || trip_addr == regs.broadcast_address) begin
          shown_r = red_tmp;
          shown_g = green_tmp;
          shown_b = w;
          hit_me  = 1'b1;
        end
        trip_addr  = trip_addr + 8'd1;
        trips_left = trips_left - 8'd1;
        ph         = (trips_left != 8'd0) ? TRIP_R : WAIT_CRC;
      end
      WAIT_CRC: ph = (w == crc_acc) ? CRC_DONE : CRC_FAIL;
      CRC_DONE: ph = TOO_LONG;
      default: ;
    endcase
  endfunction

  // one raw bus word; returns 1 with the frame report when it ends a frame
  function automatic bit deframe_word(logic [7:0] w, output slp_pkg::result_t rep);
    logic [7:0] eff;
    rep = '0;
    if (esc_seen) begin
      // escape followed by anything else is swallowed, end included
      esc_seen = 1'b0;
      if (w == slp_pkg::SLIP_TEND) parse_payload(slp_pkg::SLIP_END);
      else if (w == slp_pkg::SLIP_TESC) parse_payload(slp_pkg::SLIP_ESC);
      return 1'b0;
    end
    if (w == slp_pkg::SLIP_ESC) begin
      esc_seen = 1'b1;
      return 1'b0;
    end
    if (w != slp_pkg::SLIP_END) begin
      parse_payload(w);
      return 1'b0;
    end
    case (ph)
      CRC_DONE:  rep.frame_status = slp_pkg::ST_COMPLETE;
      TOO_LONG:  rep.frame_status = slp_pkg::ST_OVERRUN;
      CRC_FAIL:  rep.frame_status = slp_pkg::ST_BAD_CRC;
      TYPE_FAIL: rep.frame_status = slp_pkg::ST_BAD_TYPE;
      default:   rep.frame_status = slp_pkg::ST_INCOMPLETE;
    endcase
    // a triple aimed at this module makes the packet ours
    eff = hit_me ? regs.my_address : frame_addr;
    if (rep.frame_status == slp_pkg::ST_COMPLETE &&
        (eff == regs.my_address || eff == regs.broadcast_address)) begin
      case (kind_of(type_byte))
        K_NOOP:  rep.do_noop = 1'b1;
        K_RGB:   rep.do_rgb = (trips_left == 8'd0);
        K_LATCH: rep.do_latch = 1'b1;
        K_RGB_LATCH: begin
          rep.do_rgb   = (trips_left == 8'd0);
          rep.do_latch = 1'b1;
        end
        K_BAUD:  rep.do_baud = (eff == regs.broadcast_address);
        default: ;
      endcase
    end
    rep.red       = shown_r;
    rep.green     = shown_g;
    rep.blue      = shown_b;
    rep.baud_rate = baud_sr;
    ph = WAIT_ADDR;
    return 1'b1;
  endfunction

  // data byte biased toward the framing codes and the extremes
  function automatic logic [7:0] pick_data();
    case ($urandom_range(0, 15))
      0:       return slp_pkg::SLIP_END;
      1:       return slp_pkg::SLIP_ESC;
      2:       return slp_pkg::SLIP_TEND;
      3:       return slp_pkg::SLIP_TESC;
      4:       return 8'h00;
      5:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // crc, damage, slip escaping and the closing end word onto line_q
  function automatic void build_frame(input logic [7:0] body[$], input fault_e fault);
    logic [7:0] crc;
    crc = 8'h00;
    foreach (body[i]) crc = crc8_step(crc, body[i]);
    case (fault)
      F_BAD_CRC: body.push_back(crc ^ 8'($urandom_range(1, 255)));
      F_TRUNC:   repeat ($urandom_range(0, body.size() - 1)) void'(body.pop_back());
      F_OVERRUN: begin
        body.push_back(crc);
        repeat ($urandom_range(1, 3)) body.push_back(pick_data());
      end
      default:   body.push_back(crc);
    endcase
    foreach (body[i]) begin
      if (body[i] == slp_pkg::SLIP_END) begin
        line_q.push_back(slp_pkg::SLIP_ESC);
        line_q.push_back(slp_pkg::SLIP_TEND);
      end else if (body[i] == slp_pkg::SLIP_ESC) begin
        line_q.push_back(slp_pkg::SLIP_ESC);
        line_q.push_back(slp_pkg::SLIP_TESC);
      end else begin
        line_q.push_back(body[i]);
      end
    end
    line_q.push_back(slp_pkg::SLIP_END);
  endfunction

  function automatic slp_pkg::result_t plain_report(logic [2:0] st, bit noop);
    slp_pkg::result_t r;
    r = '0;
    r.frame_status = st;
    r.do_noop = noop;
    return r;
  endfunction

  function automatic void add_row(logic [7:0] w, bit typed = 1'b0,
                                  slp_pkg::result_t want = '0);
    stim_row_t row;
    row.word  = w;
    row.typed = typed;
    row.want  = want;
    stim_rows.push_back(row);
  endfunction

  function automatic string show_report(slp_pkg::result_t r);
    return $sformatf("status %0d noop %b rgb %b latch %b baud %b colour %h_%h_%h rate %h",
                     r.frame_status, r.do_noop, r.do_rgb, r.do_latch, r.do_baud,
                     r.red, r.green, r.blue, r.baud_rate);
  endfunction

  // one random frame, mostly well formed, onto line_q
  task automatic make_random_frame(input bit long_fill);
    logic [7:0]  body[$];
    logic [7:0]  t;
    logic [7:0]  count;
    int unsigned roll;
    int unsigned start;
    int unsigned pos;
    int unsigned n;
    kind_e       kind;
    fault_e      fault;
    start = line_q.size();
    roll  = long_fill ? 50 : $urandom_range(0, 99);
    if (roll < 6) begin
      // loose noise, may hold stray end words of its own
      repeat ($urandom_range(0, 6)) line_q.push_back(pick_data());
      line_q.push_back(slp_pkg::SLIP_END);
    end else begin
      // mostly this module or broadcast; just below ours so later triples hit
      case ($urandom_range(0, 9))
        0, 1, 2, 3: body.push_back(regs.my_address);
        4, 5:       body.push_back(regs.broadcast_address);
        6, 7:       body.push_back(8'(regs.my_address - $urandom_range(0, 3)));
        default:    body.push_back(8'($urandom_range(0, 255)));
      endcase
      if (roll < 12) begin
        // type byte that matches no code, junk after it
        do t = 8'($urandom_range(0, 255)); while (kind_of(t) != K_NONE);
        body.push_back(t);
        repeat ($urandom_range(0, 4)) body.push_back(pick_data());
        fault = F_CLEAN;
      end else begin
        kind = long_fill ? K_RGB : kind_e'($urandom_range(1, 5));
        case (kind)
          K_NOOP:      t = regs.code_noop;
          K_RGB:       t = regs.code_rgb;
          K_LATCH:     t = regs.code_latch;
          K_RGB_LATCH: t = regs.code_rgb_latch;
          default:     t = regs.code_baud;
        endcase
        body.push_back(t);
        case (kind)
          K_RGB, K_RGB_LATCH: begin
            // count zero stands for a full 256-triple run
            count = long_fill ? 8'd0 : 8'($urandom_range(1, 5));
            body.push_back(count);
            n = (count == 8'd0) ? 256 * 3 : count * 3;
            repeat (n) body.push_back(pick_data());
          end
          K_BAUD:  repeat (3) body.push_back(pick_data());
          default: ;
        endcase
        if (roll < 70) fault = F_CLEAN;
        else if (roll < 80) fault = F_BAD_CRC;
        else if (roll < 90) fault = F_TRUNC;
        else fault = F_OVERRUN;
      end
      build_frame(body, fault);
    end
    // now and then an escape followed by a word it cannot pair with
    if (!long_fill && $urandom_range(0, 9) == 0) begin
      pos = $urandom_range(start, line_q.size() - 1);
      t = ($urandom_range(0, 2) == 0) ? slp_pkg::SLIP_END : 8'($urandom_range(0, 255));
      if (t == slp_pkg::SLIP_TEND || t == slp_pkg::SLIP_TESC) t = 8'h00;
      line_q.insert(pos, t);
      line_q.insert(pos, slp_pkg::SLIP_ESC);
    end
  endtask

  // offer one word in bursts with random gaps, run the predictor on acceptance
  task automatic push_word(input logic [7:0] w, input bit typed,
                           input slp_pkg::result_t want);
    slp_pkg::result_t rep;
    @(negedge clk);
    if (burst_left == 0) begin
      byte_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      // an occasional long burst leaves a stretch with no gaps
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
    end
    byte_ch.valid   <= 1'b1;
    byte_ch.rx_byte <= w;
    do @(posedge clk); while (!byte_ch.ready);
    burst_left--;
    words_in++;
    if (deframe_word(w, rep)) reports_q.push_back(typed ? want : rep);
  endtask

  task automatic write_reg(input logic [slp_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      slp_pkg::CFG_MY_ADDRESS:     regs.my_address = val;
      slp_pkg::CFG_BCAST_ADDRESS:  regs.broadcast_address = val;
      slp_pkg::CFG_CRC_POLYNOMIAL: regs.crc_polynomial = val;
      slp_pkg::CFG_CODE_NOOP:      regs.code_noop = val;
      slp_pkg::CFG_CODE_RGB:       regs.code_rgb = val;
      slp_pkg::CFG_CODE_LATCH:     regs.code_latch = val;
      slp_pkg::CFG_CODE_RGB_LATCH: regs.code_rgb_latch = val;
      default:                     regs.code_baud = val;
    endcase
  endtask

  task automatic load_config(input slp_pkg::cfg_t c);
    write_reg(slp_pkg::CFG_MY_ADDRESS, c.my_address);
    write_reg(slp_pkg::CFG_BCAST_ADDRESS, c.broadcast_address);
    write_reg(slp_pkg::CFG_CRC_POLYNOMIAL, c.crc_polynomial);
    write_reg(slp_pkg::CFG_CODE_NOOP, c.code_noop);
    write_reg(slp_pkg::CFG_CODE_RGB, c.code_rgb);
    write_reg(slp_pkg::CFG_CODE_LATCH, c.code_latch);
    write_reg(slp_pkg::CFG_CODE_RGB_LATCH, c.code_rgb_latch);
    write_reg(slp_pkg::CFG_CODE_BAUD, c.code_baud);
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_run++;
  endtask

  // wait out every owed report, then the pipeline behind the last end word
  task automatic drain();
    @(negedge clk);
    byte_ch.valid <= 1'b0;
    while (reports_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // report checker, sampled at the rising edge
  always @(posedge clk) begin : report_check
    slp_pkg::result_t got;
    slp_pkg::result_t want;
    if (rst_n && report_ch.valid && report_ch.ready) begin
      got = {report_ch.frame_status, report_ch.do_noop, report_ch.do_rgb, report_ch.do_latch,
             report_ch.do_baud, report_ch.red, report_ch.green, report_ch.blue,
             report_ch.baud_rate};
      reports_done++;
      if (reports_q.size() == 0) begin
        if (report_errors < 10) $display("unexpected report: %s", show_report(got));
        report_errors++;
      end else begin
        want = reports_q.pop_front();
        status_seen[want.frame_status]++;
        if (got !== want) begin
          if (report_errors < 10) begin
            $display("report %0d mismatch", reports_done);
            $display("  expected %s", show_report(want));
            $display("  actual   %s", show_report(got));
          end
          report_errors++;
        end
      end
    end
  end

  // receiver back-pressure, changing style every so often
  initial begin : sink_pacing
    int unsigned cyc;
    pace_e       pace;
    report_ch.ready = 1'b0;
    cyc  = 0;
    pace = PACE_FREE;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc % 150 == 0) pace = pace_e'($urandom_range(0, 3));
      case (pace)
        PACE_FREE:   report_ch.ready <= 1'b1;
        PACE_BEAT:   report_ch.ready <= (cyc % 5) < 3;
        PACE_RANDOM: report_ch.ready <= ($urandom_range(0, 3) != 0);
        default:     report_ch.ready <= (cyc % 40) >= 30;
      endcase
    end
  end

  // hard stop if the dut hangs
  initial begin : watchdog
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    logic [7:0]    frame_body[$];
    slp_pkg::cfg_t c;
    int unsigned   phase_words;
    bit            long_pending;

    rst_n           = 1'b0;
    byte_ch.valid   = 1'b0;
    byte_ch.rx_byte = 8'h00;
    cfg_we          = 1'b0;
    cfg_index       = slp_pkg::CFG_MY_ADDRESS;
    cfg_wdata       = 8'h00;

    // predictor at reset
    regs = '{my_address: 8'h00, broadcast_address: 8'hFF, crc_polynomial: 8'h07,
             code_noop: 8'h00, code_rgb: 8'h01, code_latch: 8'h02,
             code_rgb_latch: 8'h03, code_baud: 8'h04};
    ph         = WAIT_ADDR;
    esc_seen   = 1'b0;
    hit_me     = 1'b0;
    crc_acc    = '0;
    frame_addr = '0;
    trip_addr  = '0;
    type_byte  = '0;
    trips_left = '0;
    red_tmp    = '0;
    green_tmp  = '0;
    shown_r    = '0;
    shown_g    = '0;
    shown_b    = '0;
    baud_sr    = '0;

    burst_left    = 0;
    words_in      = 0;
    reports_done  = 0;
    report_errors = 0;
    settings_run  = 1;
    foreach (status_seen[i]) status_seen[i] = 0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed frames under reset settings; colour and rate still zero here
    add_row(slp_pkg::SLIP_END, 1'b1, plain_report(slp_pkg::ST_INCOMPLETE, 1'b0)); // empty
    add_row(8'h00);                                               // noop to us, crc zero
    add_row(8'h00);
    add_row(8'h00);
    add_row(slp_pkg::SLIP_END, 1'b1, plain_report(slp_pkg::ST_COMPLETE, 1'b1));
    add_row(8'h00);                                               // unknown type
    add_row(8'h09);
    add_row(slp_pkg::SLIP_END, 1'b1, plain_report(slp_pkg::ST_BAD_TYPE, 1'b0));
    add_row(8'h00);                                               // noop plus a trailing word
    add_row(8'h00);
    add_row(8'h00);
    add_row(8'h7E);
    add_row(slp_pkg::SLIP_END, 1'b1, plain_report(slp_pkg::ST_OVERRUN, 1'b0));
    add_row(slp_pkg::SLIP_ESC);                                   // escape drops a plain word
    add_row(8'h41);
    add_row(slp_pkg::SLIP_ESC);                                   // escape swallows an end word
    add_row(slp_pkg::SLIP_END);
    add_row(8'h00);                                               // latch with a wrong crc
    add_row(8'h02);
    add_row(8'h01);
    add_row(slp_pkg::SLIP_END, 1'b1, plain_report(slp_pkg::ST_BAD_CRC, 1'b0));

    // broadcast baud with both framing codes and the maximum byte in its value
    frame_body = {8'hFF, 8'h04, slp_pkg::SLIP_END, slp_pkg::SLIP_ESC, 8'hFF};
    line_q.delete();
    build_frame(frame_body, F_CLEAN);
    // one colour triple aimed straight at us
    frame_body = {8'h00, 8'h01, 8'h01, 8'hAA, 8'hBB, 8'hCC};
    build_frame(frame_body, F_CLEAN);
    // colour plus latch, triple picked through the broadcast address
    frame_body = {8'hFF, 8'h03, 8'h01, slp_pkg::SLIP_ESC, 8'h00, slp_pkg::SLIP_END};
    build_frame(frame_body, F_CLEAN);
    foreach (line_q[i]) add_row(line_q[i]);

    foreach (stim_rows[i]) push_word(stim_rows[i].word, stim_rows[i].typed, stim_rows[i].want);

    // random traffic over several register settings
    for (int p = 0; p < 6; p++) begin
      case (p)
        1, 4: c = {$urandom(), $urandom()};
        2: c = '{my_address: 8'hFF, broadcast_address: 8'h00, crc_polynomial: 8'hFF,
                 code_noop: 8'hFF, code_rgb: slp_pkg::SLIP_END,
                 code_latch: slp_pkg::SLIP_ESC, code_rgb_latch: 8'h00,
                 code_baud: slp_pkg::SLIP_TESC};
        // all codes equal so noop always wins, one address for both roles
        3: c = '{my_address: 8'h00, broadcast_address: 8'h00, crc_polynomial: 8'h00,
                 code_noop: 8'h2A, code_rgb: 8'h2A, code_latch: 8'h2A,
                 code_rgb_latch: 8'h2A, code_baud: 8'h2A};
        5: begin
          // codes from a narrow range so some collide
          c = {$urandom(), $urandom()};
          c.code_noop      = 8'($urandom_range(0, 3));
          c.code_rgb       = 8'($urandom_range(0, 3));
          c.code_latch     = 8'($urandom_range(0, 3));
          c.code_rgb_latch = 8'($urandom_range(0, 3));
          c.code_baud      = 8'($urandom_range(0, 3));
        end
        default: c = regs;
      endcase
      if (p != 0) load_config(c);
      phase_words  = 0;
      long_pending = (p == 1);
      while (phase_words < 120) begin
        line_q.delete();
        make_random_frame(long_pending);
        phase_words += line_q.size();
        long_pending = 1'b0;
        foreach (line_q[i]) push_word(line_q[i], 1'b0, '0);
      end
      drain();
    end

    $display("sent %0d bus words, checked %0d frame reports over %0d register settings",
             words_in, reports_done, settings_run);
    $display("statuses: %0d complete, %0d incomplete, %0d overrun, %0d bad crc, %0d bad type",
             status_seen[slp_pkg::ST_COMPLETE], status_seen[slp_pkg::ST_INCOMPLETE],
             status_seen[slp_pkg::ST_OVERRUN], status_seen[slp_pkg::ST_BAD_CRC],
             status_seen[slp_pkg::ST_BAD_TYPE]);
    if (report_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
